### hw/rtl/cpd_pkg.sv
// ----------------------------------------------------------------------------
// cpd_pkg - command parameter deframer shared definitions
// Word types, codes and table sizes used by the deframer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package cpd_pkg;

    // Table and buffer sizes
    localparam int MAX_MODULES   = 8;
    localparam int MAX_COMMANDS  = 16;
    localparam int MAX_SIGNATURE = 8;
    localparam int MAX_PARAMS    = 8;
    localparam int RX_SIZE       = 4096;
    localparam int NUM_TYPES     = 6;

    localparam int MOD_W      = 3;
    localparam int CMD_W      = 4;
    localparam int POS_W      = 3;
    localparam int SIG_ADDR_W = MOD_W + CMD_W + POS_W;
    localparam int SIG_DEPTH  = MAX_MODULES * MAX_COMMANDS * MAX_SIGNATURE;

    // Input word kinds
    localparam logic [1:0] KIND_DATA        = 2'd0;
    localparam logic [1:0] KIND_SIG_WRITE   = 2'd1;
    localparam logic [1:0] KIND_COUNT_WRITE = 2'd2;
    localparam logic [1:0] KIND_UNUSED      = 2'd3;

    // Signature type codes
    localparam logic [2:0] CODE_END    = 3'd0;
    localparam logic [2:0] CODE_BYTE   = 3'd1;
    localparam logic [2:0] CODE_U16    = 3'd2;
    localparam logic [2:0] CODE_U32    = 3'd3;
    localparam logic [2:0] CODE_STRING = 3'd4;
    localparam logic [2:0] CODE_BLOB16 = 3'd5;
    localparam logic [2:0] CODE_BLOB32 = 3'd6;
    localparam logic [2:0] CODE_BAD    = 3'd7;

    // Result events
    localparam logic [2:0] EV_IGNORED     = 3'd0;
    localparam logic [2:0] EV_MODULE      = 3'd1;
    localparam logic [2:0] EV_COMMAND     = 3'd2;
    localparam logic [2:0] EV_PARAM       = 3'd3;
    localparam logic [2:0] EV_BLOB_LENGTH = 3'd4;
    localparam logic [2:0] EV_BAD_COMMAND = 3'd5;
    localparam logic [2:0] EV_TABLE       = 3'd6;

    typedef enum logic [2:0] {
        PH_MODULE,
        PH_COMMAND,
        PH_FIXED,
        PH_STRING,
        PH_BLOBLEN,
        PH_DONE
    } phase_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic [2:0] table_module;
        logic [3:0] table_command;
        logic [2:0] table_position;
        logic [2:0] table_code;
        logic [4:0] command_count;
    } cmd_item_t;

    typedef struct packed {
        logic [2:0]  event_res;
        logic        more_expected;
        logic [2:0]  param_type;
        logic [2:0]  param_index;
        logic [7:0]  byte_value;
        logic [12:0] rx_offset;
        logic        overflow;
        logic [2:0]  module_id;
        logic [3:0]  command_id;
        logic [31:0] blob_length;
    } res_item_t;

    typedef struct packed {
        logic                  en;
        logic [SIG_ADDR_W-1:0] addr;
        logic [2:0]            code;
    } sig_wr_t;

    typedef struct packed {
        logic                  en;
        logic [SIG_ADDR_W-1:0] addr;
    } sig_rd_t;

endpackage

`default_nettype wire

### hw/rtl/command_parameter_deframer.sv
// ----------------------------------------------------------------------------
// command_parameter_deframer - host byte stream to tagged parameter words
// Input register, single-pass decode and a result register.
// ----------------------------------------------------------------------------
// Pipeline: an accepted word is held in the input register, and its result
//   word loads into the result register when it steps, unless res_stall holds it.
// Throughput: one word per cycle while cmd_stall is low; the signature read is issued on acceptance.
// Reset: a sweep clears all 1024 signature table entries to end; cmd_stall
//   stays high until it finishes.
`default_nettype none

module command_parameter_deframer (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cmd_valid,
    output logic                      cmd_stall,
    input  wire cpd_pkg::cmd_item_t   cmd_word,
    output logic                      res_valid,
    input  wire logic                 res_stall,
    output cpd_pkg::res_item_t        res_word
);

    logic                 in_valid_reg, in_valid_next;
    cpd_pkg::cmd_item_t   in_item_reg;
    logic                 out_valid_reg, out_valid_next;
    cpd_pkg::res_item_t   out_item_reg;

    logic                 accept;
    logic                 step;
    logic                 ram_busy;
    logic [2:0]           sig_code;
    cpd_pkg::res_item_t   res_comb;
    cpd_pkg::sig_wr_t     sig_wr;
    cpd_pkg::sig_rd_t     sig_rd;
    logic [cpd_pkg::SIG_ADDR_W-1:0] sig_rd_addr;

    // Advance the held word when the result register is free or draining
    assign step      = in_valid_reg && (!out_valid_reg || !res_stall);
    assign cmd_stall = ram_busy || (in_valid_reg && !step);
    assign accept    = cmd_valid && !cmd_stall;

    assign sig_rd.en   = accept;
    assign sig_rd.addr = sig_rd_addr;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (step)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (step)
        begin
            out_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_item_reg <= cmd_word;
        end
        if (step)
        begin
            out_item_reg <= res_comb;
        end
    end

    cpd_sig_ram u_sig_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (sig_wr),
        .rd      (sig_rd),
        .rd_code (sig_code),
        .busy    (ram_busy)
    );

    cpd_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .item        (in_item_reg),
        .sig_code    (sig_code),
        .next_byte   (cmd_word.data_byte[3:0]),
        .res         (res_comb),
        .sig_wr      (sig_wr),
        .sig_rd_addr (sig_rd_addr)
    );

    assign res_valid = out_valid_reg;
    assign res_word  = out_item_reg;

endmodule

`default_nettype wire

### hw/rtl/cpd_sig_ram.sv
// ----------------------------------------------------------------------------
// cpd_sig_ram - signature table memory
// One write and one registered read port, write-first on a same-edge hit,
// and a clearing sweep after reset that sets every entry to end.
// ----------------------------------------------------------------------------
`default_nettype none

module cpd_sig_ram (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cpd_pkg::sig_wr_t  wr,
    input  wire cpd_pkg::sig_rd_t  rd,
    output logic [2:0]             rd_code,
    output logic                   busy
);

    logic [2:0] mem [cpd_pkg::SIG_DEPTH];

    logic                            clearing_reg;
    logic                            clearing_next;
    logic [cpd_pkg::SIG_ADDR_W-1:0]  clr_addr_reg;
    logic [cpd_pkg::SIG_ADDR_W-1:0]  clr_addr_next;
    logic [2:0]                      rd_code_reg;

    logic                            we;
    logic [cpd_pkg::SIG_ADDR_W-1:0]  waddr;
    logic [2:0]                      wdata;

    always_comb
    begin
        clearing_next = clearing_reg;
        clr_addr_next = clr_addr_reg;
        if (clearing_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == cpd_pkg::SIG_ADDR_W'(cpd_pkg::SIG_DEPTH - 1))
            begin
                clearing_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            clearing_reg <= clearing_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    assign we    = clearing_reg || wr.en;
    assign waddr = clearing_reg ? clr_addr_reg : wr.addr;
    assign wdata = clearing_reg ? cpd_pkg::CODE_END : wr.code;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Forward a write that lands on the address being read at the same edge
    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            if (wr.en && (wr.addr == rd.addr))
            begin
                rd_code_reg <= wr.code;
            end
            else
            begin
                rd_code_reg <= mem[rd.addr];
            end
        end
    end

    assign rd_code = rd_code_reg;
    assign busy    = clearing_reg;

endmodule

`default_nettype wire

### hw/rtl/cpd_parser.sv
// ----------------------------------------------------------------------------
// cpd_parser - frame parser state and per-word decode
// Updates the frame state for one word per step and forms its result word;
// also computes the signature address the following word will need.
// ----------------------------------------------------------------------------
`default_nettype none

module cpd_parser (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           step,
    input  wire cpd_pkg::cmd_item_t             item,
    input  wire logic [2:0]                     sig_code,
    input  wire logic [3:0]                     next_byte,
    output cpd_pkg::res_item_t                  res,
    output cpd_pkg::sig_wr_t                    sig_wr,
    output logic [cpd_pkg::SIG_ADDR_W-1:0]      sig_rd_addr
);

    cpd_pkg::phase_t phase_reg, phase_next, phase_eff;
    logic [2:0]  module_reg, module_next;
    logic [3:0]  command_reg, command_next;
    logic [3:0]  sig_pos_reg, sig_pos_next;
    logic [31:0] remaining_reg, remaining_next;
    logic [31:0] length_reg, length_next;
    logic [2:0]  len_seen_reg, len_seen_next;
    logic [2:0]  cur_type_reg, cur_type_next;
    logic [2:0]  cur_index_reg, cur_index_next;
    logic [3:0]  type_count_reg [cpd_pkg::NUM_TYPES];
    logic [3:0]  type_count_next [cpd_pkg::NUM_TYPES];
    logic [12:0] offset_reg, offset_next;
    logic        overflow_reg, overflow_next;
    logic [4:0]  cmd_count_reg [cpd_pkg::MAX_MODULES];
    logic [4:0]  cmd_count_next [cpd_pkg::MAX_MODULES];

    logic        restart;
    logic        do_adv;
    logic        adv_end;
    logic [2:0]  tidx;
    logic [2:0]  count_addr;
    logic [4:0]  cnt_sel;
    logic [31:0] shifted;
    logic [31:0] len_new;
    logic [12:0] offset_eff;
    logic [7:0]  b;

    assign b          = item.data_byte;
    assign restart    = (item.kind == cpd_pkg::KIND_DATA) && (phase_reg == cpd_pkg::PH_DONE);
    assign phase_eff  = restart ? cpd_pkg::PH_MODULE : phase_reg;
    assign offset_eff = restart ? 13'd0 : offset_reg;
    assign count_addr = (phase_eff == cpd_pkg::PH_MODULE) ? b[2:0] : module_reg;
    assign cnt_sel    = cmd_count_reg[count_addr];
    assign shifted    = 32'(b) << {len_seen_reg[1:0], 3'b000};
    assign len_new    = length_reg | shifted;
    assign tidx       = sig_code - 3'd1;

    always_comb
    begin
        phase_next      = phase_reg;
        module_next     = module_reg;
        command_next    = command_reg;
        sig_pos_next    = sig_pos_reg;
        remaining_next  = remaining_reg;
        length_next     = length_reg;
        len_seen_next   = len_seen_reg;
        cur_type_next   = cur_type_reg;
        cur_index_next  = cur_index_reg;
        type_count_next = type_count_reg;
        offset_next     = offset_reg;
        overflow_next   = overflow_reg;
        cmd_count_next  = cmd_count_reg;
        do_adv          = 1'b0;
        adv_end         = 1'b0;

        res               = '0;
        res.more_expected = 1'b1;
        res.byte_value    = b;
        res.rx_offset     = offset_reg;
        res.event_res     = cpd_pkg::EV_IGNORED;

        if (step)
        begin
            unique case (item.kind)
                cpd_pkg::KIND_SIG_WRITE:
                begin
                    res.more_expected = 1'b0;
                    res.event_res     = cpd_pkg::EV_TABLE;
                end
                cpd_pkg::KIND_COUNT_WRITE:
                begin
                    res.more_expected = 1'b0;
                    res.event_res     = cpd_pkg::EV_TABLE;
                    if (item.command_count > 5'(cpd_pkg::MAX_COMMANDS))
                    begin
                        cmd_count_next[item.table_module] = 5'(cpd_pkg::MAX_COMMANDS);
                    end
                    else
                    begin
                        cmd_count_next[item.table_module] = item.command_count;
                    end
                end
                cpd_pkg::KIND_UNUSED:
                begin
                    res.event_res = cpd_pkg::EV_IGNORED;
                end
                cpd_pkg::KIND_DATA:
                begin
                    if (restart)
                    begin
                        phase_next      = cpd_pkg::PH_MODULE;
                        type_count_next = '{default: '0};
                        offset_next     = '0;
                        overflow_next   = 1'b0;
                    end
                    res.rx_offset = offset_eff;

                    unique case (phase_eff)
                        cpd_pkg::PH_MODULE:
                        begin
                            if ((b < 8'(cpd_pkg::MAX_MODULES)) && (cnt_sel != 5'd0))
                            begin
                                module_next   = b[2:0];
                                phase_next    = cpd_pkg::PH_COMMAND;
                                res.event_res = cpd_pkg::EV_MODULE;
                            end
                        end
                        cpd_pkg::PH_COMMAND:
                        begin
                            if (b >= {3'b000, cnt_sel})
                            begin
                                phase_next    = cpd_pkg::PH_MODULE;
                                res.event_res = cpd_pkg::EV_BAD_COMMAND;
                            end
                            else
                            begin
                                command_next  = b[3:0];
                                sig_pos_next  = 4'd0;
                                res.event_res = cpd_pkg::EV_COMMAND;
                                do_adv        = 1'b1;
                            end
                        end
                        cpd_pkg::PH_FIXED, cpd_pkg::PH_STRING:
                        begin
                            res.event_res   = cpd_pkg::EV_PARAM;
                            res.param_type  = cur_type_reg;
                            res.param_index = cur_index_reg;
                            // Saturate at the end of the receive buffer
                            if (offset_reg < 13'(cpd_pkg::RX_SIZE))
                            begin
                                offset_next = offset_reg + 13'd1;
                            end
                            else
                            begin
                                offset_next   = 13'(cpd_pkg::RX_SIZE);
                                overflow_next = 1'b1;
                            end
                            if (phase_eff == cpd_pkg::PH_FIXED)
                            begin
                                if (remaining_reg <= 32'd1)
                                begin
                                    remaining_next = '0;
                                    do_adv         = 1'b1;
                                end
                                else
                                begin
                                    remaining_next = remaining_reg - 32'd1;
                                end
                            end
                            else if (b == 8'd0)
                            begin
                                do_adv = 1'b1;
                            end
                        end
                        cpd_pkg::PH_BLOBLEN:
                        begin
                            res.event_res   = cpd_pkg::EV_BLOB_LENGTH;
                            res.param_type  = cur_type_reg;
                            res.param_index = cur_index_reg;
                            length_next     = len_new;
                            len_seen_next   = len_seen_reg + 3'd1;
                            if ({29'd0, len_seen_next} >= remaining_reg)
                            begin
                                res.blob_length = len_new;
                                if (len_new == 32'd0)
                                begin
                                    // Empty blob: move on to the next entry at once
                                    remaining_next = '0;
                                    do_adv         = 1'b1;
                                end
                                else
                                begin
                                    remaining_next = len_new;
                                    phase_next     = cpd_pkg::PH_FIXED;
                                end
                            end
                        end
                        default:
                        begin
                            res.event_res = cpd_pkg::EV_IGNORED;
                        end
                    endcase

                    // Step to the next signature entry
                    if (do_adv)
                    begin
                        adv_end = (sig_pos_next >= 4'(cpd_pkg::MAX_SIGNATURE)) ||
                                  (sig_code == cpd_pkg::CODE_END) ||
                                  (sig_code == cpd_pkg::CODE_BAD);
                        if (adv_end)
                        begin
                            phase_next        = cpd_pkg::PH_DONE;
                            res.more_expected = 1'b0;
                        end
                        else
                        begin
                            sig_pos_next  = sig_pos_next + 4'd1;
                            cur_type_next = sig_code;
                            if (type_count_next[tidx] >= 4'(cpd_pkg::MAX_PARAMS))
                            begin
                                overflow_next  = 1'b1;
                                cur_index_next = 3'(cpd_pkg::MAX_PARAMS - 1);
                            end
                            else
                            begin
                                cur_index_next        = type_count_next[tidx][2:0];
                                type_count_next[tidx] = type_count_next[tidx] + 4'd1;
                            end
                            priority case (sig_code)
                                cpd_pkg::CODE_BYTE:
                                begin
                                    remaining_next = 32'd1;
                                    phase_next     = cpd_pkg::PH_FIXED;
                                end
                                cpd_pkg::CODE_U16:
                                begin
                                    remaining_next = 32'd2;
                                    phase_next     = cpd_pkg::PH_FIXED;
                                end
                                cpd_pkg::CODE_U32:
                                begin
                                    remaining_next = 32'd4;
                                    phase_next     = cpd_pkg::PH_FIXED;
                                end
                                cpd_pkg::CODE_STRING:
                                begin
                                    phase_next = cpd_pkg::PH_STRING;
                                end
                                default:
                                begin
                                    remaining_next = (sig_code == cpd_pkg::CODE_BLOB16) ?
                                                     32'd2 : 32'd4;
                                    length_next    = '0;
                                    len_seen_next  = '0;
                                    phase_next     = cpd_pkg::PH_BLOBLEN;
                                end
                            endcase
                        end
                    end
                end
            endcase
        end

        res.overflow   = overflow_next;
        res.module_id  = module_next;
        res.command_id = command_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= cpd_pkg::PH_MODULE;
            module_reg     <= '0;
            command_reg    <= '0;
            sig_pos_reg    <= '0;
            remaining_reg  <= '0;
            length_reg     <= '0;
            len_seen_reg   <= '0;
            cur_type_reg   <= '0;
            cur_index_reg  <= '0;
            type_count_reg <= '{default: '0};
            offset_reg     <= '0;
            overflow_reg   <= 1'b0;
            cmd_count_reg  <= '{default: '0};
        end
        else
        begin
            phase_reg      <= phase_next;
            module_reg     <= module_next;
            command_reg    <= command_next;
            sig_pos_reg    <= sig_pos_next;
            remaining_reg  <= remaining_next;
            length_reg     <= length_next;
            len_seen_reg   <= len_seen_next;
            cur_type_reg   <= cur_type_next;
            cur_index_reg  <= cur_index_next;
            type_count_reg <= type_count_next;
            offset_reg     <= offset_next;
            overflow_reg   <= overflow_next;
            cmd_count_reg  <= cmd_count_next;
        end
    end

    assign sig_wr.en   = step && (item.kind == cpd_pkg::KIND_SIG_WRITE);
    assign sig_wr.addr = {item.table_module, item.table_command, item.table_position};
    assign sig_wr.code = item.table_code;

    // Entry the next word needs: position 0 of the named command while a
    // command byte is expected, else the current position
    assign sig_rd_addr = {module_next,
                          (phase_next == cpd_pkg::PH_COMMAND) ? next_byte : command_next,
                          (phase_next == cpd_pkg::PH_COMMAND) ? 3'd0 : sig_pos_next[2:0]};

endmodule

`default_nettype wire
